@@ rtl/uniform_grid_broadphase_unit_macros.svh @@
// Assertion shorthands for the broadphase checker.
`ifndef UNIFORM_GRID_BROADPHASE_UNIT_MACROS_SVH
`define UNIFORM_GRID_BROADPHASE_UNIT_MACROS_SVH

// Same-cycle implication.
`define UGB_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("broadphase assertion failed");

// Next-cycle implication.
`define UGB_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("broadphase assertion failed");

`endif

@@ rtl/ugb_pkg.sv @@
package ugb_pkg;

  localparam int POS_W      = 24;
  localparam int ID_W       = 16;
  localparam int CIDX_W     = 12;
  localparam int SCALE_W    = 24;
  localparam int DIMREG_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WMIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WMIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WMIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z  = 3'd6;

  localparam logic [SCALE_W-1:0]  SCALE_RST = 24'd65536;
  localparam logic [DIMREG_W-1:0] DIM_RST   = 5'd16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    AX_MIN_X, AX_MIN_Y, AX_MIN_Z, AX_MAX_X, AX_MAX_Y, AX_MAX_Z
  } axis_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CONV, ST_WALK_INIT, ST_WALK_RD, ST_WALK_EVAL,
    ST_ENT_RD, ST_ENT_GOT, ST_FINISH
  } state_t;

  typedef struct packed {
    logic                    op;
    logic [ID_W-1:0]         collider_id;
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] min_y;
    logic signed [POS_W-1:0] min_z;
    logic signed [POS_W-1:0] max_x;
    logic signed [POS_W-1:0] max_y;
    logic signed [POS_W-1:0] max_z;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   hit_collider;
    logic [CIDX_W-1:0] cell_index;
    logic              last;
    logic              none_found;
    logic              cell_full;
    logic              truncated;
  } out_item_t;

  typedef struct packed {
    logic  clr_wr;
    logic  load;
    logic  conv_go;
    axis_t conv_axis;
    logic  walk_init;
    logic  cnt_rd;
    logic  ins_wr;
    logic  mark_full;
    logic  walk_adv;
    logic  ent_init;
    logic  ent_rd;
    logic  take_hit;
    logic  mark_trunc;
    logic  finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_query;
    logic inverted;
    logic count_full;
    logic count_zero;
    logic cell_last;
    logic ent_last;
    logic at_limit;
  } dp_stat_t;

endpackage

@@ rtl/ugb_ctrl.sv @@
module ugb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output ugb_pkg::ctrl_cmd_t   cmd,
  input  ugb_pkg::dp_stat_t    stat
);
  import ugb_pkg::*;

  // six axis issues, then wait for the multiply pipe to drain
  localparam logic [2:0] CONV_ISSUES = 3'd6;
  localparam logic [2:0] CONV_LAST   = 3'd7;

  state_t     state_r, state_nxt;
  logic [2:0] conv_cnt_r, conv_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      conv_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      conv_cnt_r <= conv_cnt_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    conv_cnt_nxt = conv_cnt_r;
    busy         = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          conv_cnt_nxt = '0;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_go   = (conv_cnt_r < CONV_ISSUES);
        cmd.conv_axis = cmd.conv_go ? axis_t'(conv_cnt_r) : AX_MIN_X;
        if (conv_cnt_r == CONV_LAST) state_nxt = ST_WALK_INIT;
        else conv_cnt_nxt = conv_cnt_r + 3'd1;
      end
      ST_WALK_INIT: begin
        if (stat.inverted) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = ST_WALK_EVAL;
      end
      ST_WALK_EVAL: begin
        if (!stat.is_query || stat.count_zero) begin
          if (!stat.is_query) begin
            if (stat.count_full) cmd.mark_full = 1'b1;
            else cmd.ins_wr = 1'b1;
          end
          if (stat.cell_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.walk_adv = 1'b1;
            state_nxt    = ST_WALK_RD;
          end
        end else begin
          cmd.ent_init = 1'b1;
          state_nxt    = ST_ENT_RD;
        end
      end
      ST_ENT_RD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = ST_ENT_GOT;
      end
      ST_ENT_GOT: begin
        if (stat.at_limit) begin
          cmd.mark_trunc = 1'b1;
          state_nxt      = ST_FINISH;
        end else begin
          cmd.take_hit = 1'b1;
          if (!stat.ent_last) begin
            state_nxt = ST_ENT_RD;
          end else if (stat.cell_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.walk_adv = 1'b1;
            state_nxt    = ST_WALK_RD;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/ugb_datapath.sv @@
module ugb_datapath #(
  parameter int DIM_MAX      = 16,
  parameter int MAX_PER_CELL = 8,
  parameter int OUT_LIMIT    = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ugb_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ugb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  ugb_pkg::in_item_t                   in_data,
  input  ugb_pkg::ctrl_cmd_t                  cmd,
  output ugb_pkg::dp_stat_t                   stat,
  output logic                                out_strobe,
  output ugb_pkg::out_item_t                  out_data
);
  import ugb_pkg::*;

  localparam int NCELLS = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int NENT   = NCELLS * MAX_PER_CELL;
  localparam int EAW    = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int CW     = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int DW     = $clog2(DIM_MAX + 1);
  localparam int NW     = $clog2(MAX_PER_CELL + 1);
  localparam int HW     = $clog2(OUT_LIMIT + 1);

  // configuration
  logic [POS_W-1:0]    wmin_x_r, wmin_y_r, wmin_z_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [DIMREG_W-1:0] dimx_r, dimy_r, dimz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmin_x_r <= '0;
      wmin_y_r <= '0;
      wmin_z_r <= '0;
      scale_r  <= SCALE_RST;
      dimx_r   <= DIM_RST;
      dimy_r   <= DIM_RST;
      dimz_r   <= DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WMIN_X: wmin_x_r <= cfg_wdata[POS_W-1:0];
        CFG_WMIN_Y: wmin_y_r <= cfg_wdata[POS_W-1:0];
        CFG_WMIN_Z: wmin_z_r <= cfg_wdata[POS_W-1:0];
        CFG_SCALE:  scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_DIM_X:  dimx_r   <= cfg_wdata[DIMREG_W-1:0];
        CFG_DIM_Y:  dimy_r   <= cfg_wdata[DIMREG_W-1:0];
        CFG_DIM_Z:  dimz_r   <= cfg_wdata[DIMREG_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] eff_dim(input logic [DIMREG_W-1:0] d);
    if (d == '0) eff_dim = DW'(1);
    else if (int'(d) > DIM_MAX) eff_dim = DW'(DIM_MAX);
    else eff_dim = DW'(d);
  endfunction

  logic [DW-1:0] dx, dy, dz;
  assign dx = eff_dim(dimx_r);
  assign dy = eff_dim(dimy_r);
  assign dz = eff_dim(dimz_r);

  in_item_t in_r;
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
  end

  // coordinate pipe: subtract, multiply, floor and clamp
  logic signed [POS_W-1:0] pos_sel, wmin_sel;
  logic signed [POS_W:0]   diff;
  always_comb begin
    unique case (cmd.conv_axis)
      AX_MIN_X: begin pos_sel = in_r.min_x; wmin_sel = wmin_x_r; end
      AX_MIN_Y: begin pos_sel = in_r.min_y; wmin_sel = wmin_y_r; end
      AX_MIN_Z: begin pos_sel = in_r.min_z; wmin_sel = wmin_z_r; end
      AX_MAX_X: begin pos_sel = in_r.max_x; wmin_sel = wmin_x_r; end
      AX_MAX_Y: begin pos_sel = in_r.max_y; wmin_sel = wmin_y_r; end
      AX_MAX_Z: begin pos_sel = in_r.max_z; wmin_sel = wmin_z_r; end
      default:  begin pos_sel = in_r.min_x; wmin_sel = wmin_x_r; end
    endcase
    diff = {pos_sel[POS_W-1], pos_sel} - {wmin_sel[POS_W-1], wmin_sel};
  end

  logic                   s1_vld_r, s2_vld_r;
  axis_t                  s1_axis_r, s2_axis_r;
  logic                   s1_pos_r, s2_pos_r;
  logic [POS_W-1:0]       s1_mag_r;
  logic [POS_W+SCALE_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.conv_go;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_axis_r <= cmd.conv_axis;
    s1_pos_r  <= !diff[POS_W] && (diff != '0);
    s1_mag_r  <= diff[POS_W-1:0];
    s2_axis_r <= s1_axis_r;
    s2_pos_r  <= s1_pos_r;
    s2_prod_r <= s1_mag_r * scale_r;
  end

  logic [DW-1:0]    dim_sel, dim_m1;
  logic [POS_W-1:0] cell_hi;
  logic [CW-1:0]    coord_val;
  logic [CW-1:0]    coord_r [6];

  always_comb begin
    unique case (s2_axis_r)
      AX_MIN_X, AX_MAX_X: dim_sel = dx;
      AX_MIN_Y, AX_MAX_Y: dim_sel = dy;
      default:            dim_sel = dz;
    endcase
    dim_m1  = dim_sel - DW'(1);
    cell_hi = s2_prod_r[POS_W+SCALE_W-1:SCALE_W];
    if (!s2_pos_r) coord_val = '0;
    else if (cell_hi >= POS_W'(dim_sel)) coord_val = CW'(dim_m1);
    else coord_val = CW'(cell_hi);
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) coord_r[s2_axis_r] <= coord_val;
  end

  // cell walk, x innermost
  logic [CW-1:0] x_r, y_r, z_r;
  logic [AW-1:0] dxy_r, idx_cur, idx_r;

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      x_r   <= coord_r[AX_MIN_X];
      y_r   <= coord_r[AX_MIN_Y];
      z_r   <= coord_r[AX_MIN_Z];
      dxy_r <= AW'(AW'(dx) * AW'(dy));
    end else if (cmd.walk_adv) begin
      if (x_r != coord_r[AX_MAX_X]) begin
        x_r <= x_r + CW'(1);
      end else begin
        x_r <= coord_r[AX_MIN_X];
        if (y_r != coord_r[AX_MAX_Y]) begin
          y_r <= y_r + CW'(1);
        end else begin
          y_r <= coord_r[AX_MIN_Y];
          z_r <= z_r + CW'(1);
        end
      end
    end
  end

  assign idx_cur = AW'(x_r) + AW'(AW'(y_r) * AW'(dx)) + AW'(AW'(z_r) * dxy_r);

  // per-cell fill counts, cleared by a sweep after reset
  logic [NW-1:0] cnt_mem [NCELLS];
  logic [NW-1:0] cnt_q_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_wr) clr_addr_r <= clr_addr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) cnt_mem[clr_addr_r] <= '0;
    else if (cmd.ins_wr) cnt_mem[idx_r] <= cnt_q_r + NW'(1);
    if (cmd.cnt_rd) begin
      cnt_q_r <= cnt_mem[idx_cur];
      idx_r   <= idx_cur;
    end
  end

  // stored ids
  logic [ID_W-1:0] ent_mem [NENT];
  logic [ID_W-1:0] ent_q_r;
  logic [NW-1:0]   e_r, ent_cnt_r;
  logic [EAW-1:0]  ent_base, ent_wr_addr, ent_rd_addr;

  assign ent_base    = EAW'(EAW'(idx_r) * EAW'(MAX_PER_CELL));
  assign ent_wr_addr = ent_base + EAW'(cnt_q_r);
  assign ent_rd_addr = ent_base + EAW'(e_r);

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) ent_mem[ent_wr_addr] <= in_r.collider_id;
    if (cmd.ent_rd) ent_q_r <= ent_mem[ent_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ent_init) begin
      ent_cnt_r <= cnt_q_r;
      e_r       <= '0;
    end else if (cmd.take_hit) begin
      e_r <= e_r + NW'(1);
    end
  end

  // one hit held back so the final one can carry last
  logic              pend_vld_r, full_r, trunc_r;
  logic [HW-1:0]     hits_r;
  logic [ID_W-1:0]   pend_id_r;
  logic [CIDX_W-1:0] pend_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      full_r     <= 1'b0;
      trunc_r    <= 1'b0;
      hits_r     <= '0;
    end else if (cmd.load) begin
      pend_vld_r <= 1'b0;
      full_r     <= 1'b0;
      trunc_r    <= 1'b0;
      hits_r     <= '0;
    end else begin
      if (cmd.mark_full) full_r <= 1'b1;
      if (cmd.mark_trunc) trunc_r <= 1'b1;
      if (cmd.take_hit) begin
        pend_vld_r <= 1'b1;
        hits_r     <= hits_r + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      pend_id_r  <= ent_q_r;
      pend_idx_r <= CIDX_W'(idx_r);
    end
  end

  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_data_r, out_data_nxt;

  always_comb begin
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    if (cmd.take_hit && pend_vld_r) begin
      out_strobe_nxt = 1'b1;
      out_data_nxt   = '{pend_id_r, pend_idx_r, 1'b0, 1'b0, 1'b0, 1'b0};
    end else if (cmd.finish) begin
      out_strobe_nxt = 1'b1;
      if (in_r.op == OP_QUERY && pend_vld_r)
        out_data_nxt = '{pend_id_r, pend_idx_r, 1'b1, 1'b0, 1'b0, trunc_r};
      else
        out_data_nxt = '{'0, '0, 1'b1, 1'b1, full_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else out_strobe_r <= out_strobe_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign stat.clr_done   = (clr_addr_r == AW'(NCELLS - 1));
  assign stat.is_query   = (in_r.op == OP_QUERY);
  assign stat.inverted   = (coord_r[AX_MIN_X] > coord_r[AX_MAX_X]) ||
                           (coord_r[AX_MIN_Y] > coord_r[AX_MAX_Y]) ||
                           (coord_r[AX_MIN_Z] > coord_r[AX_MAX_Z]);
  assign stat.count_full = (cnt_q_r >= NW'(MAX_PER_CELL));
  assign stat.count_zero = (cnt_q_r == '0);
  assign stat.cell_last  = (x_r == coord_r[AX_MAX_X]) && (y_r == coord_r[AX_MAX_Y]) &&
                           (z_r == coord_r[AX_MAX_Z]);
  assign stat.ent_last   = ((e_r + NW'(1)) == ent_cnt_r);
  assign stat.at_limit   = (hits_r == HW'(OUT_LIMIT));

endmodule

@@ rtl/uniform_grid_broadphase_unit.sv @@
// Flow: the six corner conversions (one shared 24x24 multiplier) run first, then
// the walk starts and reads the count of each covered cell, and on a query reads the
// stored ids there, then the last result is registered. One item in flight, busy
// high meanwhile; the next item can be taken in the cycle the last result shows.
// After reset the cell count memory is swept clear, all DIM_MAX**3 cells (4096 by
// default), with busy high. Results are one-cycle strobes; the receiver cannot stall.
module uniform_grid_broadphase_unit #(
  parameter int DIM_MAX      = 16,
  parameter int MAX_PER_CELL = 8,
  parameter int OUT_LIMIT    = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ugb_pkg::in_item_t               in_data,
  output logic                            out_strobe,
  output ugb_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [ugb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ugb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ugb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ugb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  ugb_datapath #(
    .DIM_MAX      (DIM_MAX),
    .MAX_PER_CELL (MAX_PER_CELL),
    .OUT_LIMIT    (OUT_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

@@ rtl/ugb_checker.sv @@
`include "uniform_grid_broadphase_unit_macros.svh"

module ugb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input ugb_pkg::out_item_t  out_data
);
  import ugb_pkg::*;

  `UGB_AST_IMP(a_none_is_last, out_strobe && out_data.none_found, out_data.last)
  `UGB_AST_IMP(a_trunc_on_final_hit, out_strobe && out_data.truncated, out_data.last && !out_data.none_found)
  `UGB_AST_IMP(a_full_only_on_ack, out_strobe && out_data.cell_full, out_data.none_found)
  `UGB_AST_NXT(a_start_goes_busy, start && !busy, busy)
  `UGB_AST_NXT(a_gap_after_last, out_strobe && out_data.last, !out_strobe)

endmodule

bind uniform_grid_broadphase_unit ugb_checker u_ugb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
